/* design/assert_macros.svh */
// Assertion macros shared by the hole table allocator RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define HTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising clock edge outside of reset.
`define HTA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* design/hta_pkg.sv */
// Package for the hole table fit allocator: sizes, codes and shared types.
// No dependencies; imported by hta_cmp_unit and the top level.
package hta_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int SIZE_BITS   = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Request functions.
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_ALLOC  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Fit policies.
  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_WORST = 2'd2;
  localparam logic [1:0] STRAT_NEXT  = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_SHIFT  = 4'b1000
  } state_t;

  // Flags returned by the shared compare unit.
  typedef struct packed {
    logic a_ge_b;
    logic a_lt_c;
    logic a_gt_c;
  } cmp_flags_t;

endpackage

/* design/hta_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module hta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/hta_cmp_unit.sv */
// Shared compare and subtract unit of the hole table allocator.
// Depends on hta_pkg for the size width and the flag struct.
module hta_cmp_unit
  import hta_pkg::*;
(
  input  logic [SIZE_BITS-1:0] op_a,
  input  logic [SIZE_BITS-1:0] op_b,
  input  logic [SIZE_BITS-1:0] op_c,
  output cmp_flags_t           flags,
  output logic [SIZE_BITS-1:0] diff
);

  // Fit test against the request, rank test against the current candidate.
  always_comb begin
    flags.a_ge_b = (op_a >= op_b);
    flags.a_lt_c = (op_a < op_c);
    flags.a_gt_c = (op_a > op_c);
  end

  // Size left after taking the request out of a hole.
  assign diff = op_a - op_b;

endmodule

/* design/hole_table_fit_allocator_unit.sv */
// Hole table fit allocator: top level with sequencer, table RAM and compare unit.
// Depends on hta_pkg, hta_ram, hta_cmp_unit and assert_macros.svh.
// An append, a zero request or an allocate on an empty table answers in the cycle
// after start; a scan reads the filled holes in turn (stopping sooner when first or next
// fit hits), and removing an exactly used hole keeps busy while the later holes move down,
// one RAM read a cycle.
// Reset (rst_n low, synchronous) empties the table, zeroes the rover and selects first fit.
// The result strobe lasts one cycle; the receiver cannot stall it.
`include "assert_macros.svh"

module hole_table_fit_allocator_unit
  import hta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic [SIZE_BITS-1:0] in_request_size,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic                 out_exact_fit,
  output logic [IDX_W-1:0]     out_entry_index,
  output logic [SIZE_BITS-1:0] out_remaining_size,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_strategy
);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     rover_r, rover_nxt;
  logic [1:0]           strategy_r;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]     pend_pos_r, pend_pos_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_pos_r, best_pos_nxt;
  logic [SIZE_BITS-1:0] best_size_r, best_size_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic                 out_exact_r, out_exact_nxt;
  logic [IDX_W-1:0]     out_index_r, out_index_nxt;
  logic [SIZE_BITS-1:0] out_rem_r, out_rem_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;

  logic [SIZE_BITS-1:0] cmp_a;
  cmp_flags_t           cmp_flags;
  logic [SIZE_BITS-1:0] cmp_diff;

  logic                 seq_policy;
  logic                 hit_stop;
  logic                 better;
  logic [CNT_W-1:0]     pos_inc;

  // Hole size table.
  hta_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Shared compare unit: tests the hole just read, or the chosen hole at the end.
  hta_cmp_unit u_cmp (
    .op_a (cmp_a),
    .op_b (req_r),
    .op_c (best_size_r),
    .flags(cmp_flags),
    .diff (cmp_diff)
  );

  assign cmp_a = (state_r == S_DECIDE) ? best_size_r : ram_rdata;

  // Scan helpers.
  assign seq_policy = (strategy_r == STRAT_FIRST) || (strategy_r == STRAT_NEXT);
  assign hit_stop   = (state_r == S_SCAN) && pend_vld_r && cmp_flags.a_ge_b && seq_policy;
  assign better     = !found_r ||
                      ((strategy_r == STRAT_BEST) && cmp_flags.a_lt_c) ||
                      ((strategy_r == STRAT_WORST) && cmp_flags.a_gt_c);
  assign pos_inc    = pos_r + CNT_W'(1);

  // Sequencer and datapath control.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rover_nxt      = rover_r;
    req_nxt        = req_r;
    pos_nxt        = pos_r;
    issue_nxt      = issue_r;
    pend_vld_nxt   = 1'b0;
    pend_pos_nxt   = pend_pos_r;
    found_nxt      = found_r;
    best_pos_nxt   = best_pos_r;
    best_size_nxt  = best_size_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_exact_nxt  = out_exact_r;
    out_index_nxt  = out_index_r;
    out_rem_nxt    = out_rem_r;
    ram_we         = 1'b0;
    ram_waddr      = best_pos_r;
    ram_wdata      = cmp_diff;
    ram_raddr      = pos_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt       = in_request_size;
          out_valid_nxt = 1'b1;
          out_exact_nxt = 1'b0;
          out_index_nxt = '0;
          out_rem_nxt   = '0;
          if (in_func == FUNC_APPEND) begin
            if (count_r == CNT_W'(TABLE_DEPTH)) begin
              out_status_nxt = ST_FULL;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = count_r[IDX_W-1:0];
              ram_wdata      = in_request_size;
              out_status_nxt = ST_DONE;
              out_index_nxt  = count_r[IDX_W-1:0];
              out_rem_nxt    = in_request_size;
              count_nxt      = count_r + CNT_W'(1);
            end
          end else if ((in_request_size == '0) || (count_r == '0)) begin
            out_status_nxt = ST_NOFIT;
          end else begin
            // Start a scan; next fit begins at the rover when it is still in range.
            out_valid_nxt = 1'b0;
            state_nxt     = S_SCAN;
            issue_nxt     = '0;
            found_nxt     = 1'b0;
            if ((strategy_r == STRAT_NEXT) && (CNT_W'(rover_r) < count_r)) begin
              pos_nxt = CNT_W'(rover_r);
            end else begin
              pos_nxt = '0;
            end
          end
        end
      end

      S_SCAN: begin
        // Judge the hole read in the previous cycle.
        if (pend_vld_r && cmp_flags.a_ge_b && (seq_policy || better)) begin
          found_nxt     = 1'b1;
          best_pos_nxt  = pend_pos_r;
          best_size_nxt = ram_rdata;
        end
        // Issue the next read, wrapping round the filled part of the table.
        if (!hit_stop && (issue_r != count_r)) begin
          pend_vld_nxt = 1'b1;
          pend_pos_nxt = pos_r[IDX_W-1:0];
          pos_nxt      = (pos_inc == count_r) ? '0 : pos_inc;
          issue_nxt    = issue_r + CNT_W'(1);
        end
        if (hit_stop || ((issue_r == count_r) && !pend_vld_r)) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (!found_r) begin
          out_status_nxt = ST_NOFIT;
          out_exact_nxt  = 1'b0;
          out_index_nxt  = '0;
          out_rem_nxt    = '0;
        end else begin
          out_status_nxt = ST_DONE;
          out_index_nxt  = best_pos_r;
          out_rem_nxt    = cmp_diff;
          out_exact_nxt  = (cmp_diff == '0);
          if (cmp_diff != '0) begin
            ram_we = 1'b1;
            if (strategy_r == STRAT_NEXT) begin
              rover_nxt = best_pos_r;
            end
          end else begin
            // Hole used up: drop it and move the later holes down.
            count_nxt    = count_r - CNT_W'(1);
            pos_nxt      = CNT_W'(best_pos_r) + CNT_W'(1);
            pend_vld_nxt = 1'b0;
            state_nxt    = S_SHIFT;
            if (strategy_r == STRAT_NEXT) begin
              rover_nxt = (CNT_W'(best_pos_r) < (count_r - CNT_W'(1))) ? best_pos_r : '0;
            end
          end
        end
      end

      S_SHIFT: begin
        // Write back the entry read last cycle one place lower.
        if (pend_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_pos_r;
          ram_wdata = ram_rdata;
        end
        if (pos_r <= count_r) begin
          pend_vld_nxt = 1'b1;
          pend_pos_nxt = pos_r[IDX_W-1:0] - IDX_W'(1);
          pos_nxt      = pos_inc;
        end else if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rover_r     <= '0;
      strategy_r  <= STRAT_FIRST;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rover_r     <= rover_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        strategy_r <= cfg_strategy;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    pos_r        <= pos_nxt;
    issue_r      <= issue_nxt;
    pend_pos_r   <= pend_pos_nxt;
    found_r      <= found_nxt;
    best_pos_r   <= best_pos_nxt;
    best_size_r  <= best_size_nxt;
    out_status_r <= out_status_nxt;
    out_exact_r  <= out_exact_nxt;
    out_index_r  <= out_index_nxt;
    out_rem_r    <= out_rem_nxt;
  end

  // Ports.
  assign busy               = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_exact_fit      = out_exact_r;
  assign out_entry_index    = out_index_r;
  assign out_remaining_size = out_rem_r;

  // Assertions.
  `HTA_NEVER(a_count_range, count_r > CNT_W'(TABLE_DEPTH), "hole count above table depth")
  `HTA_ASSERT(a_append_result, (start && !busy && (in_func == FUNC_APPEND)) |=> out_valid_r, "append request without result next cycle")
  `HTA_ASSERT(a_exact_result, (out_valid_r && out_exact_r) |-> ((out_rem_r == '0) && (out_status_r == ST_DONE)), "exact fit result with size left")
  `HTA_ASSERT(a_count_drop, (count_r < $past(count_r)) |-> (out_valid_r && out_exact_r), "hole removed without exact fit result")
  `HTA_ASSERT(a_scan_bound, ((state_r == S_SCAN) && pend_vld_r) |-> (CNT_W'(pend_pos_r) < count_r), "scan read beyond filled entries")

endmodule
